// ===== design/cdd_pkg.sv =====
package cdd_pkg;

    // Largest year accepted; larger input years are clamped to it.
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    // ceil(2^19 / 12): floor(n * RECIP_12 / 2^19) == n / 12 for any 15-bit n.
    localparam logic [15:0] RECIP_12 = 16'd43691;

    localparam logic [13:0] YEARS_400 = 14'd400;

    typedef enum logic [2:0] {
        REQ_DAYS     = 3'd0,
        REQ_WEEKS    = 3'd1,
        REQ_MONTHS   = 3'd2,
        REQ_YEARS    = 3'd3,
        REQ_DECADES  = 3'd4,
        REQ_YEAR_SUB = 3'd5
    } t_req;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  in_day;
        logic [3:0]  in_month;
        logic [13:0] in_year;
        logic [14:0] step_count;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [13:0] out_year;
        logic        underflow;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_PREP,
        ST_DAYS,
        ST_MONS,
        ST_YEARS,
        ST_CLAMP,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLAMP,
        OP_PREP,
        OP_DAY,
        OP_MON,
        OP_YEAR
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       day_fin;
    } t_dp_stat;

    // year mod 400 by restoring subtraction, six narrow steps
    function automatic logic [8:0] f_mod400(input logic [13:0] year);
        logic [13:0] v;
        v = year;
        for (int k = 5; k >= 0; k--) begin
            if (v >= (YEARS_400 << k)) begin
                v = v - (YEARS_400 << k);
            end
        end
        return v[8:0];
    endfunction

    function automatic logic f_leap(input logic [8:0] y400);
        return (y400[1:0] == 2'd0) && (y400 != 9'd100) && (y400 != 9'd200)
            && (y400 != 9'd300);
    endfunction

    function automatic logic [4:0] f_dim(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== design/calendar_date_decrement_unit.sv =====
// Calendar date decrement unit: takes a Gregorian date (day, month, year), a
// count and a unit (days, weeks, months, years, decades, or a plain year
// subtract) and returns the earlier date with an underflow flag; results
// that would fall before 1 January of year 1 saturate there with underflow
// set. The start date is clamped into range first (year 1..9999, month
// 1..12, day 1..month length). One transaction is worked on at a time. From
// input acceptance to the result register, month, year and decade requests
// pass normalize, prep, month step and day clamp states, the plain year
// subtract normalize, prep and a year step, other codes normalize and prep.
// Day and week requests walk a day counter back one calendar month or, from
// 31 December, one whole year per cycle. The next request is taken once the
// result is in the output register, even while that result waits on a
// downstream stall.
module calendar_date_decrement_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cdd_pkg::t_in_item  i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cdd_pkg::t_out_item o_out_data
);
    import cdd_pkg::*;

    // command and status between the sequencer and the date datapath
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: request acceptance, walk control, result register valid
    cdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // datapath: date registers, day/month/year stepping, result register
    cdd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule

// ===== design/cdd_ctrl.sv =====
module cdd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output cdd_pkg::t_dp_cmd  o_cmd,
    input  cdd_pkg::t_dp_stat i_stat
);
    import cdd_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_in_acc;
    logic   w_out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_in_acc) n_state = ST_NORM;
            ST_NORM:  n_state = ST_PREP;
            ST_PREP: begin
                case (i_stat.mode) inside
                    REQ_DAYS, REQ_WEEKS:                n_state = ST_DAYS;
                    REQ_MONTHS, REQ_YEARS, REQ_DECADES: n_state = ST_MONS;
                    REQ_YEAR_SUB:                       n_state = ST_YEARS;
                    default:                            n_state = ST_DONE;
                endcase
            end
            ST_DAYS:  if (i_stat.day_fin) n_state = ST_DONE;
            ST_MONS:  n_state = ST_CLAMP;
            ST_YEARS: n_state = ST_DONE;
            ST_CLAMP: n_state = ST_DONE;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.out_load = 1'b0;
        case (r_state)
            ST_IDLE:  o_cmd.op = w_in_acc ? OP_LOAD : OP_NONE;
            ST_NORM:  o_cmd.op = OP_CLAMP;
            ST_PREP:  o_cmd.op = OP_PREP;
            ST_DAYS:  o_cmd.op = OP_DAY;
            ST_MONS:  o_cmd.op = OP_MON;
            ST_YEARS: o_cmd.op = OP_YEAR;
            ST_CLAMP: o_cmd.op = OP_CLAMP;
            ST_DONE:  o_cmd.out_load = w_out_free;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_NORM))
        else $error("accepted transaction did not start normalization");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a pending transaction");

    a_load_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("loaded result not presented");

endmodule

// ===== design/cdd_dpath.sv =====
module cdd_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdd_pkg::t_in_item  i_in_data,
    input  cdd_pkg::t_dp_cmd   i_cmd,
    output cdd_pkg::t_dp_stat  o_stat,
    output cdd_pkg::t_out_item o_out_data
);
    import cdd_pkg::*;

    logic [2:0]  r_mode;
    logic [14:0] r_cnt;
    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [13:0] r_year;
    logic [8:0]  r_y400;
    logic [18:0] r_acc;
    logic        r_under;
    t_out_item   r_out;

    // current-year helpers (valid once r_y400 tracks r_year)
    logic        w_leap;
    logic [8:0]  w_ylen;
    logic [8:0]  w_y400_dec;
    logic [3:0]  w_month_dec;

    // day walk
    logic        w_fits;
    logic        w_yjump;
    logic        w_wrap;
    logic        w_day_under;

    // day clamp
    logic [8:0]  w_cl_y400;
    logic [4:0]  w_cl_lim;

    // month/year walk
    logic [30:0] w_prod;
    logic [14:0] w_q12;
    logic [3:0]  w_mb;
    logic        w_borrow;
    logic [18:0] w_yb;

    assign w_leap      = f_leap(r_y400);
    assign w_ylen      = w_leap ? 9'd366 : 9'd365;
    assign w_y400_dec  = (r_y400 == 9'd0) ? 9'd399 : r_y400 - 9'd1;
    assign w_month_dec = r_month - 4'd1;

    assign w_fits      = r_acc < 19'(r_day);
    assign w_yjump     = !w_fits && (r_month == 4'd12) && (r_day == 5'd31)
                         && (r_acc >= 19'(w_ylen));
    assign w_wrap      = (r_month == 4'd1);
    assign w_day_under = !w_fits && (r_year == 14'd1) && (w_yjump || w_wrap);

    assign w_cl_y400   = f_mod400(r_year);
    assign w_cl_lim    = f_dim(r_month, f_leap(w_cl_y400));

    assign w_prod      = 31'(r_cnt) * 31'(RECIP_12);
    assign w_q12       = {r_acc[11:0], 3'b000} + {1'b0, r_acc[11:0], 2'b00};
    assign w_mb        = (r_mode == REQ_MONTHS) ? 4'(r_cnt - w_q12) : 4'd0;
    assign w_borrow    = (r_month <= w_mb);
    assign w_yb        = r_acc + 19'(w_borrow);

    assign o_stat.mode    = r_mode;
    assign o_stat.day_fin = w_fits || w_day_under;
    assign o_out_data     = r_out;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_mode  <= i_in_data.req_type;
                r_cnt   <= i_in_data.step_count;
                r_day   <= i_in_data.in_day;
                r_under <= 1'b0;
                if (i_in_data.in_month == 4'd0) begin
                    r_month <= 4'd1;
                end else if (i_in_data.in_month > 4'd12) begin
                    r_month <= 4'd12;
                end else begin
                    r_month <= i_in_data.in_month;
                end
                if (i_in_data.in_year == 14'd0) begin
                    r_year <= 14'd1;
                end else if (i_in_data.in_year > YEAR_MAX) begin
                    r_year <= YEAR_MAX;
                end else begin
                    r_year <= i_in_data.in_year;
                end
            end
            OP_CLAMP: begin
                r_y400 <= w_cl_y400;
                if (r_day == 5'd0) begin
                    r_day <= 5'd1;
                end else if (r_day > w_cl_lim) begin
                    r_day <= w_cl_lim;
                end
            end
            OP_PREP: begin
                case (r_mode) inside
                    REQ_WEEKS:   r_acc <= {1'b0, r_cnt, 3'b000} - 19'(r_cnt);
                    REQ_MONTHS:  r_acc <= 19'(w_prod[30:19]);
                    REQ_DECADES: r_acc <= {1'b0, r_cnt, 3'b000} + {3'b000, r_cnt, 1'b0};
                    default:     r_acc <= 19'(r_cnt);
                endcase
            end
            OP_DAY: begin
                if (w_fits) begin
                    r_day <= r_day - r_acc[4:0];
                end else if (w_day_under) begin
                    r_under <= 1'b1;
                end else if (w_yjump) begin
                    // Dec 31 to Dec 31 of the year before
                    r_year <= r_year - 14'd1;
                    r_y400 <= w_y400_dec;
                    r_acc  <= r_acc - 19'(w_ylen);
                end else begin
                    // back to the last day of the previous month
                    r_acc <= r_acc - 19'(r_day);
                    if (w_wrap) begin
                        r_month <= 4'd12;
                        r_day   <= 5'd31;
                        r_year  <= r_year - 14'd1;
                        r_y400  <= w_y400_dec;
                    end else begin
                        r_month <= w_month_dec;
                        r_day   <= f_dim(w_month_dec, w_leap);
                    end
                end
            end
            OP_MON: begin
                if (w_yb >= 19'(r_year)) begin
                    r_under <= 1'b1;
                end else begin
                    r_year  <= r_year - w_yb[13:0];
                    r_month <= w_borrow ? r_month + 4'd12 - w_mb : r_month - w_mb;
                end
            end
            OP_YEAR: begin
                if (r_cnt >= 15'(r_year)) begin
                    r_under <= 1'b1;
                end else begin
                    r_year <= r_year - r_cnt[13:0];
                end
            end
            default: begin
            end
        endcase

        if (i_cmd.out_load) begin
            if (r_under) begin
                r_out <= '{out_day: 5'd1, out_month: 4'd1, out_year: 14'd1,
                           underflow: 1'b1};
            end else begin
                r_out <= '{out_day: r_day, out_month: r_month, out_year: r_year,
                           underflow: 1'b0};
            end
        end
    end

    a_load_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_LOAD) |=> ((r_month >= 4'd1) && (r_month <= 4'd12)
            && (r_year != 14'd0) && (r_year <= YEAR_MAX) && !r_under))
        else $error("start date not clamped on load");

    a_clamp_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_CLAMP) |=> ((r_day != 5'd0) && (r_y400 < 9'd400)))
        else $error("day clamp left a bad day or year phase");

    a_day_step_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.op == OP_DAY) && !w_fits && !w_day_under)
            |=> ((r_year != 14'd0) && (r_day >= 5'd28)))
        else $error("day walk left a month or year boundary wrong");

endmodule
